// ===== design/kdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kdpq_pkg
// Shared types and constants of the key debounce press queue.
// ----------------------------------------------------------------------------
package kdpq_pkg;

    localparam int KEY_LEVELS_W = 6;   // width of the key level bus
    localparam int TIME_W       = 16;  // debounce and hold time registers
    localparam int CNT_W        = 17;  // per-key tick counter
    localparam int KEY_W        = 3;   // key index carried in an event
    localparam int DROP_W       = 3;   // dropped event count per tick
    localparam int CFG_ADDR_W   = 2;

    localparam int CMD_DEPTH    = 4;   // request queue between front and back
    localparam int CMD_PTR_W    = 2;
    localparam int CMD_CNT_W    = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_DOWN_TIME = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME = 2'd1;

    localparam logic [TIME_W-1:0] DOWN_TIME_RST = 16'd2;
    localparam logic [TIME_W-1:0] HOLD_TIME_RST = 16'd70;

    // one result of the block
    typedef struct packed {
        logic              msg_valid;
        logic [KEY_W-1:0]  msg_key;
        logic              msg_long;
        logic              queue_empty;
        logic              queue_full;
        logic [DROP_W-1:0] dropped;
    } res_t;

endpackage

// ===== design/kdpq_front.sv =====
// ----------------------------------------------------------------------------
// kdpq_front
// Per-key debounce machines. A scan tick updates every key at once and emits
// the masks of keys released this tick; a read passes with its masks cleared.
// ----------------------------------------------------------------------------
module kdpq_front #(
    parameter int NUM_KEYS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [kdpq_pkg::KEY_LEVELS_W-1:0]   s_key_levels,
    input  logic [kdpq_pkg::TIME_W-1:0]         down_time,
    input  logic [kdpq_pkg::TIME_W-1:0]         hold_time,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output logic                                cmd_is_read,
    output logic [NUM_KEYS-1:0]                 cmd_ev_mask,
    output logic [NUM_KEYS-1:0]                 cmd_long_mask
);
    import kdpq_pkg::*;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_DOWN     = 2'd2;
    localparam logic [1:0] PH_HOLD     = 2'd3;

    logic [1:0]       phase_reg  [NUM_KEYS];
    logic [1:0]       phase_next [NUM_KEYS];
    logic [CNT_W-1:0] cnt_reg    [NUM_KEYS];
    logic [CNT_W-1:0] cnt_next   [NUM_KEYS];
    logic [NUM_KEYS-1:0] released;
    logic [NUM_KEYS-1:0] ev_mask;
    logic [NUM_KEYS-1:0] long_mask;
    logic [CNT_W-1:0] down_lim;
    logic [CNT_W-1:0] hold_lim;
    logic             tick;

    // keys past the level bus always read as released
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
        if (k < KEY_LEVELS_W) begin : g_pin
            assign released[k] = s_key_levels[k];
        end else begin : g_none
            assign released[k] = 1'b1;
        end
    end

    assign down_lim = {1'b0, down_time};
    assign hold_lim = {1'b0, hold_time} + CNT_W'(1);

    assign s_ready       = cmd_ready;
    assign cmd_valid     = s_valid;
    assign cmd_is_read   = s_mode;
    assign cmd_ev_mask   = s_mode ? '0 : ev_mask;
    assign cmd_long_mask = s_mode ? '0 : long_mask;
    assign tick          = s_valid && cmd_ready && !s_mode;

    always_comb begin
        logic [CNT_W-1:0] inc;
        for (int k = 0; k < NUM_KEYS; k++) begin
            inc           = cnt_reg[k] + CNT_W'(1);
            phase_next[k] = phase_reg[k];
            cnt_next[k]   = cnt_reg[k];
            ev_mask[k]    = 1'b0;
            long_mask[k]  = 1'b0;
            case (phase_reg[k])
                PH_IDLE: begin
                    if (!released[k]) begin
                        phase_next[k] = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE: begin
                    if (released[k]) begin
                        phase_next[k] = PH_IDLE;
                        cnt_next[k]   = '0;
                    end else if (inc >= down_lim) begin
                        phase_next[k] = PH_DOWN;
                        cnt_next[k]   = '0;
                    end else begin
                        cnt_next[k]   = inc;
                    end
                end
                PH_DOWN: begin
                    if (released[k]) begin
                        phase_next[k] = PH_IDLE;
                        cnt_next[k]   = '0;
                        ev_mask[k]    = 1'b1;
                    end else if (inc >= hold_lim) begin
                        phase_next[k] = PH_HOLD;
                        cnt_next[k]   = '0;
                    end else begin
                        cnt_next[k]   = inc;
                    end
                end
                default: begin
                    if (released[k]) begin
                        phase_next[k] = PH_IDLE;
                        ev_mask[k]    = 1'b1;
                        long_mask[k]  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                phase_reg[k] <= PH_IDLE;
                cnt_reg[k]   <= '0;
            end
        end else if (tick) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                phase_reg[k] <= phase_next[k];
                cnt_reg[k]   <= cnt_next[k];
            end
        end
    end

endmodule

// ===== design/kdpq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// kdpq_cmd_fifo
// Short request queue between the key machines and the event queue.
// ----------------------------------------------------------------------------
module kdpq_cmd_fifo #(
    parameter int W = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import kdpq_pkg::*;

    logic [W-1:0]         slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CMD_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CMD_CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/kdpq_back.sv =====
// ----------------------------------------------------------------------------
// kdpq_back
// Event queue. Pushes the released keys of a tick one per cycle in key
// order, pops one event per read, and holds the result register.
// ----------------------------------------------------------------------------
module kdpq_back #(
    parameter int NUM_KEYS    = 6,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic                  cmd_is_read,
    input  logic [NUM_KEYS-1:0]   cmd_ev_mask,
    input  logic [NUM_KEYS-1:0]   cmd_long_mask,
    output logic                  res_valid,
    input  logic                  res_ready,
    output kdpq_pkg::res_t        res
);
    import kdpq_pkg::*;

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = KEY_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [ENTRY_W-1:0]  mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [1:0]          state_reg,   state_next;
    logic [NUM_KEYS-1:0] pend_reg,    pend_next;
    logic [NUM_KEYS-1:0] long_reg,    long_next;
    logic [DROP_W-1:0]   drop_reg,    drop_next;
    logic [AW-1:0]       wr_ptr_reg,  wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg,  rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,   count_next;
    logic                out_vld_reg, out_vld_next;
    res_t                out_reg,     out_next;

    logic                load;
    logic                mem_we;
    logic [KEY_W-1:0]    sel_key;
    logic                sel_long;
    logic [NUM_KEYS-1:0] sel_bit;
    logic                q_full;

    assign q_full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_ready = (state_reg == ST_IDLE) && (!out_vld_reg || res_ready);
    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    // lowest pending key goes first
    always_comb begin
        logic found;
        found    = 1'b0;
        sel_key  = '0;
        sel_long = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (!found && pend_reg[i]) begin
                found    = 1'b1;
                sel_key  = KEY_W'(i);
                sel_long = long_reg[i];
            end
        end
        sel_bit = pend_reg & (~pend_reg + NUM_KEYS'(1));
    end

    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        long_next   = long_reg;
        drop_next   = drop_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        load        = 1'b0;
        out_next    = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    if (cmd_is_read) begin
                        if (count_reg == '0) begin
                            load = 1'b1;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else if (cmd_ev_mask == '0) begin
                        load = 1'b1;
                    end else begin
                        pend_next  = cmd_ev_mask;
                        long_next  = cmd_long_mask;
                        drop_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (q_full) begin
                    drop_next = drop_reg + DROP_W'(1);
                end else begin
                    mem_we      = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                  : wr_ptr_reg + AW'(1);
                    count_next  = count_reg + QCNT_W'(1);
                end
                pend_next = pend_reg & ~sel_bit;
                if (pend_next == '0) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + AW'(1);
                count_next  = count_reg - QCNT_W'(1);
                load        = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            out_next.msg_valid   = (state_reg == ST_READ);
            out_next.msg_key     = (state_reg == ST_READ) ? rd_data_reg[ENTRY_W-1:1] : '0;
            out_next.msg_long    = (state_reg == ST_READ) ? rd_data_reg[0] : 1'b0;
            out_next.queue_empty = (count_next == '0);
            out_next.queue_full  = (count_next == QCNT_W'(QUEUE_DEPTH));
            out_next.dropped     = (state_reg == ST_SCAN) ? drop_next : '0;
        end

        if (load) begin
            out_vld_next = 1'b1;
        end else if (res_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // event storage; reads are registered and only used in the read state
    // that follows idle, when no write is in flight
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= {sel_key, sel_long};
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        long_reg <= long_next;
        drop_reg <= drop_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ===== design/key_debounce_press_queue.sv =====
// ----------------------------------------------------------------------------
// key_debounce_press_queue
// Key debounce with short and long press event queue.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A scan tick (mode 0) advances all
// key machines in the cycle it is taken and passes the released keys on
// through a four-entry request queue, so the input side takes one request
// per cycle until that queue fills. The event queue side then loads the
// result straight from idle for a tick with no releases or a read of an
// empty queue, goes through a read state for a read that pops an event
// (registered memory read), and goes through a scan state for a tick with
// releases, where events are written into the event memory one per cycle.
// It starts the next request only once the result register is free. No
// clearing pass after reset.
module key_debounce_press_queue #(
    parameter int NUM_KEYS    = 6,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kdpq_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [kdpq_pkg::TIME_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [kdpq_pkg::KEY_LEVELS_W-1:0]   s_key_levels,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_msg_valid,
    output logic [kdpq_pkg::KEY_W-1:0]          m_msg_key,
    output logic                                m_msg_long,
    output logic                                m_queue_empty,
    output logic                                m_queue_full,
    output logic [kdpq_pkg::DROP_W-1:0]         m_dropped
);
    import kdpq_pkg::*;

    localparam int CMD_W = 1 + 2 * NUM_KEYS;

    logic [TIME_W-1:0]   down_time_reg;
    logic [TIME_W-1:0]   hold_time_reg;

    logic                f_valid, f_ready, f_is_read;
    logic [NUM_KEYS-1:0] f_ev_mask, f_long_mask;
    logic                b_valid, b_ready;
    logic [CMD_W-1:0]    b_data;
    res_t                res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_time_reg <= DOWN_TIME_RST;
            hold_time_reg <= HOLD_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DOWN_TIME: down_time_reg <= cfg_data;
                CFG_HOLD_TIME: hold_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kdpq_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key_levels  (s_key_levels),
        .down_time     (down_time_reg),
        .hold_time     (hold_time_reg),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd_is_read   (f_is_read),
        .cmd_ev_mask   (f_ev_mask),
        .cmd_long_mask (f_long_mask)
    );

    kdpq_cmd_fifo #(
        .W (CMD_W)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_is_read, f_ev_mask, f_long_mask}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    kdpq_back #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (b_valid),
        .cmd_ready     (b_ready),
        .cmd_is_read   (b_data[CMD_W-1]),
        .cmd_ev_mask   (b_data[2*NUM_KEYS-1:NUM_KEYS]),
        .cmd_long_mask (b_data[NUM_KEYS-1:0]),
        .res_valid     (m_valid),
        .res_ready     (m_ready),
        .res           (res)
    );

    assign m_msg_valid   = res.msg_valid;
    assign m_msg_key     = res.msg_key;
    assign m_msg_long    = res.msg_long;
    assign m_queue_empty = res.queue_empty;
    assign m_queue_full  = res.queue_full;
    assign m_dropped     = res.dropped;

`ifndef SYNTH
    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_queue_empty && m_queue_full))
        else $error("queue reported empty and full at once");

    a_pop_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_msg_valid) |-> (m_dropped == '0))
        else $error("read result reports dropped events");

    a_pop_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_msg_valid) |-> !m_queue_full)
        else $error("queue full right after a pop");
`endif

endmodule
